### src/bpc_pkg.sv
// shared types and constants for the beat phase clock
// no dependencies; every other file imports this package

package bpc_pkg;

   // field widths of the channels
   localparam int MODE_W  = 2;
   localparam int BSIZE_W = 14;
   localparam int TEMPO_W = 16;
   localparam int PHASE_W = 17;
   localparam int RATE_W  = 18;
   localparam int FRAC_W  = 17;
   localparam int LEN_W   = 32;
   localparam int POS_W   = 33;

   // multiplier and divider widths
   localparam int MUL_A_W = 17;
   localparam int PROD_W  = MUL_A_W + LEN_W;
   localparam int DIV_W   = POS_W + 16;
   localparam int CNT_W   = $clog2(DIV_W + 1);

   // fixed values
   localparam logic [TEMPO_W-1:0] TEMPO_RESET      = 16'd31744;
   localparam logic [RATE_W-1:0]  RATE_RESET       = 18'd44100;
   localparam logic [TEMPO_W-1:0] TEMPO_MIN        = 16'd256;
   localparam logic [PHASE_W-1:0] PHASE_ONE        = 17'd65536;
   localparam logic [MUL_A_W-1:0] BEAT_SCALE       = 17'd15360;
   localparam logic [LEN_W-1:0]   FALLBACK_SAMPLES = 32'd21338;

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_ADVANCE   = 2'd0,
      MODE_SET_TEMPO = 2'd1,
      MODE_SET_PHASE = 2'd2,
      MODE_NOP       = 2'd3
   } mode_type;

   // multiplier operand selection
   typedef enum logic [1:0] {
      MUL_RATE  = 2'd0,
      MUL_FRAC  = 2'd1,
      MUL_PHASE = 2'd2
   } mul_sel_type;

   // divider operand selection
   typedef enum logic [1:0] {
      DIV_LEN  = 2'd0,
      DIV_MOD  = 2'd1,
      DIV_FRAC = 2'd2
   } div_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic        capture;
      logic        set_tempo;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        len_load;
      logic        pos_from_prod;
      logic        pos_add;
      logic        pos_from_rem;
      logic        frac_load;
      logic        out_load;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      mode_type mode;
      logic     need_rescale;
      logic     tempo_zero;
      logic     phase_valid;
      logic     div_done;
   } dp_status_type;

endpackage

### src/bpc_if.sv
// channel interfaces: request, response and register write
// depends on bpc_pkg for field widths

interface bpc_req_if import bpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [BSIZE_W-1:0] buffer_size;
   logic [TEMPO_W-1:0] tempo_in;
   logic [PHASE_W-1:0] phase_in;

   modport source (output valid, mode, buffer_size, tempo_in, phase_in, input ready);
   modport sink   (input valid, mode, buffer_size, tempo_in, phase_in, output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FRAC_W-1:0]  beat_fraction;
   logic [LEN_W-1:0]   beat_samples;
   logic [TEMPO_W-1:0] tempo_out;

   modport source (output valid, beat_fraction, beat_samples, tempo_out, input ready);
   modport sink   (input valid, beat_fraction, beat_samples, tempo_out, output ready);
endinterface

interface bpc_csr_if import bpc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] sample_rate;

   modport source (output valid, sample_rate, input ready);
   modport sink   (input valid, sample_rate, output ready);
endinterface

### src/bpc_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on bpc_pkg for widths

module bpc_divider
   import bpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [LEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [LEN_W-1:0] remainder
);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             done_ff, done_in;
   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             fits;

   // one shift-compare-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   // next state of the iteration
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         count_in = CNT_W'(DIV_W);
      end else if (count_ff != '0) begin
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         rem_in   = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### src/bpc_datapath.sv
// datapath: tempo, beat length and position state, shared multiplier,
// divider and result register; depends on bpc_pkg and bpc_divider

module bpc_datapath
   import bpc_pkg::*;
#(
   parameter int FRACTION_BITS = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [BSIZE_W-1:0] req_buffer_size,
   input  logic [TEMPO_W-1:0] req_tempo_in,
   input  logic [PHASE_W-1:0] req_phase_in,
   input  logic               csr_write,
   input  logic [RATE_W-1:0]  csr_sample_rate,
   output logic [FRAC_W-1:0]  rsp_beat_fraction,
   output logic [LEN_W-1:0]   rsp_beat_samples,
   output logic [TEMPO_W-1:0] rsp_tempo_out
);

   localparam logic [63:0] RESET_LEN_WIDE =
      ((64'(RATE_RESET) * 64'(BEAT_SCALE)) << FRACTION_BITS) / 64'(TEMPO_RESET);
   localparam logic [LEN_W-1:0] RESET_LEN = RESET_LEN_WIDE[LEN_W-1:0];
   localparam logic [63:0] FALLBACK_WIDE = 64'(FALLBACK_SAMPLES) << FRACTION_BITS;
   localparam logic [LEN_W-1:0] FALLBACK_LEN = FALLBACK_WIDE[LEN_W-1:0];

   // block state
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [TEMPO_W-1:0] tempo_ff, tempo_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [RATE_W-1:0]  last_rate_ff, last_rate_in;
   logic [TEMPO_W-1:0] last_tempo_ff, last_tempo_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;

   // captured transaction and working values
   mode_type           mode_ff;
   logic [BSIZE_W-1:0] bsize_ff;
   logic [TEMPO_W-1:0] tin_ff;
   logic [PHASE_W-1:0] pin_ff;
   logic [PROD_W-1:0]  prod_ff;

   // result register
   logic [FRAC_W-1:0]  out_frac_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic [TEMPO_W-1:0] out_tempo_ff;

   logic [TEMPO_W-1:0] tin_clamped;
   logic [RATE_W-1:0]  rescale_rate;
   logic [MUL_A_W-1:0] mul_a;
   logic [LEN_W-1:0]   mul_b;
   logic [DIV_W-1:0]   div_dividend;
   logic [LEN_W-1:0]   div_divisor;
   logic               div_done;
   logic [DIV_W-1:0]   div_quotient;
   logic [LEN_W-1:0]   div_remainder;
   logic [LEN_W-1:0]   len_from_div;
   logic [FRAC_W-1:0]  frac_from_div;
   logic [POS_W-1:0]   frames;

   // tempo clamp and rate used by a rescale
   always_comb begin
      tin_clamped  = (tin_ff < TEMPO_MIN) ? TEMPO_MIN : tin_ff;
      rescale_rate = (mode_ff == MODE_SET_TEMPO) ? last_rate_ff : rate_ff;
   end

   // status towards the controller
   always_comb begin
      status.mode        = mode_ff;
      status.tempo_zero  = (tin_ff == '0);
      status.phase_valid = (pin_ff <= PHASE_ONE);
      status.div_done    = div_done;
      case (mode_ff)
         MODE_ADVANCE:   status.need_rescale = (rate_ff != last_rate_ff) ||
                                               (tempo_ff != last_tempo_ff);
         MODE_SET_TEMPO: status.need_rescale = (tin_clamped != last_tempo_ff);
         default:        status.need_rescale = 1'b0;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_RATE: begin
            mul_a = BEAT_SCALE;
            mul_b = LEN_W'(rescale_rate);
         end
         MUL_FRAC: begin
            mul_a = frac_ff;
            mul_b = len_ff;
         end
         MUL_PHASE: begin
            mul_a = pin_ff;
            mul_b = len_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider operands
   always_comb begin
      case (cmd.div_sel)
         DIV_LEN: begin
            div_dividend = DIV_W'(prod_ff[LEN_W-1:0]) << FRACTION_BITS;
            div_divisor  = LEN_W'(tempo_ff);
         end
         DIV_MOD: begin
            div_dividend = DIV_W'(pos_ff);
            div_divisor  = len_ff;
         end
         DIV_FRAC: begin
            div_dividend = {pos_ff, 16'b0};
            div_divisor  = len_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   bpc_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // beat length saturation and fallback, fraction limit
   always_comb begin
      if (div_quotient[DIV_W-1:LEN_W] != '0) begin
         len_from_div = '1;
      end else if (div_quotient == '0) begin
         len_from_div = FALLBACK_LEN;
      end else begin
         len_from_div = div_quotient[LEN_W-1:0];
      end
      if (div_quotient > DIV_W'(PHASE_ONE)) begin
         frac_from_div = PHASE_ONE;
      end else begin
         frac_from_div = div_quotient[FRAC_W-1:0];
      end
      frames = POS_W'(bsize_ff[BSIZE_W-1:1]) << FRACTION_BITS;
   end

   // next block state
   always_comb begin
      rate_in       = rate_ff;
      tempo_in      = tempo_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      last_rate_in  = last_rate_ff;
      last_tempo_in = last_tempo_ff;
      frac_in       = frac_ff;
      if (csr_write) begin
         rate_in = csr_sample_rate;
      end
      if (cmd.set_tempo) begin
         tempo_in = tin_clamped;
      end
      if (cmd.len_load) begin
         len_in        = len_from_div;
         last_rate_in  = rescale_rate;
         last_tempo_in = tempo_ff;
      end
      if (cmd.pos_from_prod) begin
         pos_in = prod_ff[PROD_W-1:16];
      end else if (cmd.pos_add) begin
         pos_in = pos_ff + frames;
      end else if (cmd.pos_from_rem) begin
         pos_in = POS_W'(div_remainder);
      end
      if (cmd.frac_load) begin
         frac_in = frac_from_div;
      end
   end

   // block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff       <= RATE_RESET;
         tempo_ff      <= TEMPO_RESET;
         len_ff        <= RESET_LEN;
         pos_ff        <= '0;
         last_rate_ff  <= RATE_RESET;
         last_tempo_ff <= TEMPO_RESET;
         frac_ff       <= '0;
      end else begin
         rate_ff       <= rate_in;
         tempo_ff      <= tempo_in;
         len_ff        <= len_in;
         pos_ff        <= pos_in;
         last_rate_ff  <= last_rate_in;
         last_tempo_ff <= last_tempo_in;
         frac_ff       <= frac_in;
      end
   end

   // captured transaction, product and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         bsize_ff <= req_buffer_size;
         tin_ff   <= req_tempo_in;
         pin_ff   <= req_phase_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (cmd.out_load) begin
         out_frac_ff  <= frac_ff;
         out_len_ff   <= len_ff;
         out_tempo_ff <= tempo_ff;
      end
   end

   assign rsp_beat_fraction = out_frac_ff;
   assign rsp_beat_samples  = out_len_ff;
   assign rsp_tempo_out     = out_tempo_ff;

endmodule

### src/bpc_ctrl.sv
// controller: sequences rescale, advance, phase set and response hand-off
// depends on bpc_pkg for command, status and mode types

module bpc_ctrl
   import bpc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_DECODE    = 13'b0000000000010,
      ST_LEN_MUL   = 13'b0000000000100,
      ST_LEN_DIV   = 13'b0000000001000,
      ST_LEN_WAIT  = 13'b0000000010000,
      ST_POS_MUL   = 13'b0000000100000,
      ST_POS_LOAD  = 13'b0000001000000,
      ST_ADV_ADD   = 13'b0000010000000,
      ST_MOD_DIV   = 13'b0000100000000,
      ST_MOD_WAIT  = 13'b0001000000000,
      ST_FRAC_DIV  = 13'b0010000000000,
      ST_FRAC_WAIT = 13'b0100000000000,
      ST_RESULT    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state sequencing and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.mode)
               MODE_ADVANCE: begin
                  state_in = status.need_rescale ? ST_LEN_MUL : ST_ADV_ADD;
               end
               MODE_SET_TEMPO: begin
                  if (status.tempo_zero) begin
                     state_in = ST_RESULT;
                  end else begin
                     cmd.set_tempo = 1'b1;
                     state_in      = status.need_rescale ? ST_LEN_MUL : ST_RESULT;
                  end
               end
               MODE_SET_PHASE: begin
                  state_in = status.phase_valid ? ST_POS_MUL : ST_RESULT;
               end
               default: state_in = ST_RESULT;
            endcase
         end
         ST_LEN_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RATE;
            state_in    = ST_LEN_DIV;
         end
         ST_LEN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_LEN;
            state_in      = ST_LEN_WAIT;
         end
         ST_LEN_WAIT: begin
            if (status.div_done) begin
               cmd.len_load = 1'b1;
               state_in     = ST_POS_MUL;
            end
         end
         ST_POS_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = (status.mode == MODE_SET_PHASE) ? MUL_PHASE : MUL_FRAC;
            state_in    = ST_POS_LOAD;
         end
         ST_POS_LOAD: begin
            cmd.pos_from_prod = 1'b1;
            state_in = (status.mode == MODE_ADVANCE) ? ST_ADV_ADD : ST_FRAC_DIV;
         end
         ST_ADV_ADD: begin
            cmd.pos_add = 1'b1;
            state_in    = ST_MOD_DIV;
         end
         ST_MOD_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MOD;
            state_in      = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (status.div_done) begin
               cmd.pos_from_rem = 1'b1;
               state_in         = ST_FRAC_DIV;
            end
         end
         ST_FRAC_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FRAC;
            state_in      = ST_FRAC_WAIT;
         end
         ST_FRAC_WAIT: begin
            if (status.div_done) begin
               cmd.frac_load = 1'b1;
               state_in      = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // the result register is free once the previous response has gone
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/beat_phase_clock_unit.sv
// channel    | dir | signals
// req_ch     | in  | valid, ready, mode, buffer_size, tempo_in, phase_in
// rsp_ch     | out | valid, ready, beat_fraction, beat_samples, tempo_out
// csr_ch     | in  | valid, ready (always high), sample_rate
//
// one transaction at a time; a bit-serial divider of 49 steps sets the time.
// an advance rescales first when the tempo or rate has changed, and a set tempo
// rescales when the new tempo differs; a set phase and an ignored request skip it.
// reset is synchronous: tempo 124 bpm, rate 44100, position zero.
// a waiting response holds only the result register; the next request is
// taken meanwhile and stalls at the end until the response has gone.
// depends on bpc_pkg, bpc_if, bpc_ctrl and bpc_datapath

module beat_phase_clock_unit
   import bpc_pkg::*;
#(
   parameter int FRACTION_BITS = 8
)
(
   input  logic clock,
   input  logic reset,
   bpc_req_if.sink   req_ch,
   bpc_rsp_if.source rsp_ch,
   bpc_csr_if.sink   csr_ch
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   bpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bpc_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_ch.mode),
      .req_buffer_size   (req_ch.buffer_size),
      .req_tempo_in      (req_ch.tempo_in),
      .req_phase_in      (req_ch.phase_in),
      .csr_write         (csr_ch.valid),
      .csr_sample_rate   (csr_ch.sample_rate),
      .rsp_beat_fraction (rsp_ch.beat_fraction),
      .rsp_beat_samples  (rsp_ch.beat_samples),
      .rsp_tempo_out     (rsp_ch.tempo_out)
   );

endmodule

### bench/beat_phase_clock_unit_tb.sv
// testbench for beat_phase_clock_unit: tempo, phase and advance requests
// checked against a predictor of the beat clock kept inside the bench
// depends on bpc_pkg, bpc_if and the beat_phase_clock_unit rtl
`timescale 1ns / 1ps

module beat_phase_clock_unit_tb;
   import bpc_pkg::*;

   localparam int FRACTION_BITS  = 8;
   localparam int RESET_CYCLES   = 8;
   localparam int HOLD_OFF       = 300;
   localparam int DRAIN_CYCLES   = 200;
   localparam int WATCHDOG_LIMIT = 5000;

   // one expected response
   typedef struct {
      logic [FRAC_W-1:0]  fraction;
      logic [LEN_W-1:0]   samples;
      logic [TEMPO_W-1:0] tempo;
   } beat_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpc_req_if req_ch ();
   bpc_rsp_if rsp_ch ();
   bpc_csr_if csr_ch ();

   beat_phase_clock_unit #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predicted clock state and register copy
   logic [RATE_W-1:0]  rate_cfg;
   logic [TEMPO_W-1:0] tempo_now;
   logic [LEN_W-1:0]   beat_len;
   logic [POS_W-1:0]   beat_pos;
   logic [RATE_W-1:0]  prev_rate;
   logic [TEMPO_W-1:0] prev_tempo;

   beat_report_type report_q[$];

   bit idle_on;
   bit stall_on;
   int hold_left;
   int stall_left;
   int quiet_cycles;
   int error_count;
   int sent_count;
   int checked_count;
   int rate_writes;

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // beat length in samples, fixed point, for a rate and tempo
   function automatic logic [LEN_W-1:0] beat_length_for(logic [RATE_W-1:0] rate,
                                                       logic [TEMPO_W-1:0] bpm);
      logic [63:0] scaled;
      logic [63:0] divisor;
      logic [63:0] quotient;
      divisor  = (bpm == '0) ? 64'(TEMPO_MIN) : 64'(bpm);
      scaled   = (64'(rate) * 64'(BEAT_SCALE)) << FRACTION_BITS;
      quotient = scaled / divisor;
      if (quotient > 64'hFFFF_FFFF) quotient = 64'hFFFF_FFFF;
      // a zero length falls back to a fixed beat
      if (quotient == 64'd0) quotient = 64'(FALLBACK_SAMPLES) << FRACTION_BITS;
      return quotient[LEN_W-1:0];
   endfunction

   // position as a fraction of the beat, limited to one
   function automatic logic [FRAC_W-1:0] fraction_of_beat();
      logic [63:0] ratio;
      if (beat_len == '0) return '0;
      ratio = (64'(beat_pos) << 16) / 64'(beat_len);
      if (ratio > 64'(PHASE_ONE)) ratio = 64'(PHASE_ONE);
      return ratio[FRAC_W-1:0];
   endfunction

   // new beat length on a tempo or rate change, keeping the fraction
   function automatic void rescale_beat(logic [RATE_W-1:0] rate, logic [TEMPO_W-1:0] bpm);
      logic [63:0] kept;
      logic [63:0] product;
      if (rate == prev_rate && bpm == prev_tempo) return;
      kept       = 64'(fraction_of_beat());
      prev_tempo = bpm;
      beat_len   = beat_length_for(rate, bpm);
      prev_rate  = rate;
      product    = kept * 64'(beat_len);
      beat_pos   = product[16 +: POS_W];
   endfunction

   function automatic void reset_prediction();
      rate_cfg   = RATE_RESET;
      tempo_now  = TEMPO_RESET;
      prev_tempo = TEMPO_RESET;
      prev_rate  = RATE_RESET;
      beat_pos   = '0;
      beat_len   = beat_length_for(RATE_RESET, TEMPO_RESET);
   endfunction

   // applies one request to the predicted state and returns the report
   function automatic beat_report_type predict_report(mode_type m, logic [BSIZE_W-1:0] bsize,
                                                      logic [TEMPO_W-1:0] tin,
                                                      logic [PHASE_W-1:0] pin);
      beat_report_type    report;
      logic [63:0]        sum;
      logic [63:0]        product;
      logic [TEMPO_W-1:0] bpm;
      case (m)
         MODE_ADVANCE: begin
            rescale_beat(rate_cfg, tempo_now);
            sum      = 64'(beat_pos) + ((64'(bsize) >> 1) << FRACTION_BITS);
            beat_pos = sum[POS_W-1:0];
            if (beat_len == '0) beat_len = FALLBACK_SAMPLES << FRACTION_BITS;
            sum      = 64'(beat_pos) % 64'(beat_len);
            beat_pos = sum[POS_W-1:0];
         end
         MODE_SET_TEMPO: begin
            // zero tempo is ignored, below one bpm is clamped
            if (tin != '0) begin
               bpm       = (tin < TEMPO_MIN) ? TEMPO_MIN : tin;
               tempo_now = bpm;
               rescale_beat(prev_rate, bpm);
            end
         end
         MODE_SET_PHASE: begin
            if (pin <= PHASE_ONE) begin
               product  = 64'(pin) * 64'(beat_len);
               beat_pos = product[16 +: POS_W];
            end
         end
         default: ;
      endcase
      report.fraction = fraction_of_beat();
      report.samples  = beat_len;
      report.tempo    = tempo_now;
      return report;
   endfunction

   // sends one request transaction and records its expected response
   task automatic send_request(mode_type m, logic [BSIZE_W-1:0] bsize,
                               logic [TEMPO_W-1:0] tin, logic [PHASE_W-1:0] pin);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.mode        = m;
      req_ch.buffer_size = bsize;
      req_ch.tempo_in    = tin;
      req_ch.phase_in    = pin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      report_q.push_back(predict_report(m, bsize, tin, pin));
      sent_count++;
   endtask

   // drops the request valid and waits for every response
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (report_q.size() != 0) @(posedge clock);
   endtask

   // sample rate write, only with the unit idle
   task automatic write_rate(logic [RATE_W-1:0] rate);
      wait_idle();
      @(negedge clock);
      csr_ch.valid       = 1'b1;
      csr_ch.sample_rate = rate;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      rate_cfg = rate;
      rate_writes++;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(0, 9))
         0:       return 18'd8000;
         1:       return 18'd192000;
         2:       return '1;
         3:       return 18'd48000;
         default: return RATE_W'($urandom_range(8000, 192000));
      endcase
   endfunction

   // mostly advances at musical tempi, with odd requests mixed in
   task automatic send_random_request();
      int                 roll;
      mode_type           m;
      logic [BSIZE_W-1:0] bsize;
      logic [TEMPO_W-1:0] tin;
      logic [PHASE_W-1:0] pin;
      roll  = $urandom_range(0, 99);
      bsize = BSIZE_W'($urandom_range(0, 8192));
      if ($urandom_range(0, 15) == 0) bsize = BSIZE_W'($urandom);
      case ($urandom_range(0, 9))
         0:       tin = '0;
         1:       tin = TEMPO_W'($urandom_range(1, 255));
         2:       tin = TEMPO_W'($urandom);
         default: tin = TEMPO_W'($urandom_range(15360, 51200));
      endcase
      pin = PHASE_W'($urandom_range(0, 65536));
      if ($urandom_range(0, 9) == 0) pin = PHASE_W'($urandom_range(65537, 131071));
      if (roll < 62)      m = MODE_ADVANCE;
      else if (roll < 80) m = MODE_SET_TEMPO;
      else if (roll < 95) m = MODE_SET_PHASE;
      else                m = MODE_NOP;
      send_request(m, bsize, tin, pin);
   endtask

   task automatic test_advance_edges();
      send_request(MODE_ADVANCE, '0, '0, '0);
      send_request(MODE_ADVANCE, 14'd1, '1, '1);
      send_request(MODE_ADVANCE, 14'd8192, '0, '0);
      send_request(MODE_ADVANCE, '1, '1, '1);
      send_request(MODE_ADVANCE, 14'd2048, 16'h5A5A, 17'h0A5A5);
   endtask

   task automatic test_tempo_requests();
      send_request(MODE_SET_TEMPO, '1, '0, '1);
      send_request(MODE_SET_TEMPO, '0, 16'd1, '0);
      send_request(MODE_ADVANCE, 14'd4096, '0, '0);
      send_request(MODE_SET_TEMPO, '0, 16'd255, '0);
      send_request(MODE_SET_TEMPO, '0, TEMPO_MIN, '0);
      send_request(MODE_SET_TEMPO, '0, '1, '0);
      send_request(MODE_ADVANCE, 14'd1000, '0, '0);
      send_request(MODE_SET_TEMPO, '0, TEMPO_RESET, '0);
   endtask

   task automatic test_phase_requests();
      send_request(MODE_SET_PHASE, '1, '1, '0);
      send_request(MODE_SET_PHASE, '0, '0, PHASE_ONE);
      send_request(MODE_SET_PHASE, '0, '0, 17'd65537);
      send_request(MODE_SET_PHASE, '0, '0, '1);
      send_request(MODE_SET_PHASE, '0, '0, 17'd32768);
      send_request(MODE_ADVANCE, 14'd512, '0, '0);
   endtask

   task automatic test_unused_mode();
      send_request(MODE_NOP, '1, '1, '1);
      send_request(MODE_NOP, '0, '0, '0);
   endtask

   // each rate then an advance, a tempo change and three random requests; zero rate hits the fallback beat
   task automatic test_rate_sweep();
      logic [RATE_W-1:0] rates[6];
      int                i;
      int                k;
      rates = '{18'd8000, 18'd192000, 18'd0, 18'h3FFFF, 18'd48000, RATE_RESET};
      for (i = 0; i < 6; i++) begin
         write_rate(rates[i]);
         send_request(MODE_ADVANCE, BSIZE_W'($urandom_range(0, 8192)), '0, '0);
         send_request(MODE_SET_TEMPO, '0, TEMPO_W'($urandom_range(256, 65535)), '0);
         for (k = 0; k < 3; k++) send_random_request();
      end
      send_request(MODE_SET_TEMPO, '0, TEMPO_MIN, '0);
      send_request(MODE_ADVANCE, 14'd8192, '0, '0);
   endtask

   // long receiver hold-off while requests keep coming
   task automatic test_output_hold();
      int i;
      wait_idle();
      hold_left = HOLD_OFF;
      for (i = 0; i < 8; i++) send_random_request();
   endtask

   task automatic test_random_traffic();
      int n;
      for (n = 0; n < 380; n++) begin
         if (n % 60 == 59) write_rate(pick_rate());
         send_random_request();
      end
   endtask

   // no gaps on either side
   task automatic test_steady_stream();
      int n;
      write_rate(pick_rate());
      idle_on  = 1'b0;
      stall_on = 1'b0;
      for (n = 0; n < 60; n++) send_random_request();
   endtask

   // response ready: hold-off first, then random stall bursts
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready = 1'b0;
         stall_left   = $urandom_range(1, 8) - 1;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin : check_reports
      beat_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (report_q.size() == 0) begin
            $display("%0t unexpected response: fraction %0d samples %0d tempo %0d", $time,
                     rsp_ch.beat_fraction, rsp_ch.beat_samples, rsp_ch.tempo_out);
            error_count++;
         end else begin
            want = report_q.pop_front();
            checked_count++;
            if (rsp_ch.beat_fraction !== want.fraction) begin
               $display("%0t beat_fraction: expected %0d actual %0d", $time,
                        want.fraction, rsp_ch.beat_fraction);
               error_count++;
            end
            if (rsp_ch.beat_samples !== want.samples) begin
               $display("%0t beat_samples: expected %0d actual %0d", $time,
                        want.samples, rsp_ch.beat_samples);
               error_count++;
            end
            if (rsp_ch.tempo_out !== want.tempo) begin
               $display("%0t tempo_out: expected %0d actual %0d", $time,
                        want.tempo, rsp_ch.tempo_out);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t timeout: no transaction for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, report_q.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.mode        = '0;
      req_ch.buffer_size = '0;
      req_ch.tempo_in    = '0;
      req_ch.phase_in    = '0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.sample_rate = '0;
      idle_on            = 1'b1;
      stall_on           = 1'b1;
      hold_left          = 0;
      stall_left         = 0;
      quiet_cycles       = 0;
      error_count        = 0;
      sent_count         = 0;
      checked_count      = 0;
      rate_writes        = 0;
      reset_prediction();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_advance_edges();
      test_tempo_requests();
      test_phase_requests();
      test_unused_mode();
      test_rate_sweep();
      test_output_hold();
      test_random_traffic();
      test_steady_stream();

      // drain and settle
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests, %0d responses checked, %0d sample rate writes",
               sent_count, checked_count, rate_writes);
      $display("advance, tempo, phase and unused requests with stalls and a long hold-off");
      if (error_count == 0 && report_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d responses missing", error_count, report_q.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
